>>> rtl/msr_pkg.sv
`default_nettype none

package msr_pkg;

    localparam int MAX_SIDE = 64;
    localparam int IDX_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int ADDR_W = 2 * IDX_W;
    localparam int DEPTH = MAX_SIDE * MAX_SIDE;

    localparam int ELEM_W = 16;
    localparam int SIDE_W = 7;
    localparam int SUM_W = 29;
    localparam int PRE_W = ELEM_W + IDX_W + 1;
    localparam int STRIP_W = PRE_W + 1;

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic [SIDE_W-1:0] side_t;
    typedef logic signed [SUM_W-1:0] sum_t;
    typedef logic signed [PRE_W-1:0] pre_t;
    typedef logic signed [STRIP_W-1:0] strip_t;
    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [ADDR_W-1:0] addr_t;

    localparam sum_t SUM_MOST_NEG = {1'b1, {(SUM_W-1){1'b0}}};
    localparam idx_t LAST_MAX = IDX_W'(MAX_SIDE - 1);

    typedef enum logic [3:0] {
        ST_LOAD  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

endpackage

`default_nettype wire

>>> rtl/msr_ram.sv
`default_nettype none

module msr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                       clk,
    input  wire logic                                       wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                           wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> rtl/max_sum_rectangle.sv
`default_nettype none

// Finds the largest sum of any rectangular submatrix of an n-by-n matrix of
// signed 16-bit elements, with n taken from side_length (0 acts as 1, values
// above 64 act as 64). Elements are taken in row-major order, one per cycle
// while loading, and stored as row prefix sums in two identical 4096-entry
// memories. After the last element, the block stops taking requests and runs
// Kadane's scan for every column pair; a single accumulate unit fed by one read
// port of each memory performs one row step per cycle, followed by a pipeline
// drain. The result is held in an output register, so the next matrix can load
// while it waits. A write to side_length discards a partly loaded matrix.
module max_sum_rectangle (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           config_valid,
    output logic                config_ready,
    input  wire msr_pkg::side_t side_length,
    input  wire logic           element_valid,
    output logic                element_stall,
    input  wire msr_pkg::elem_t element,
    output logic                result_valid,
    input  wire logic           result_stall,
    output msr_pkg::sum_t       max_sum
);

    import msr_pkg::*;

    state_t state_reg, state_next;
    idx_t   side_last_reg;
    idx_t   ld_row_reg, ld_col_reg;
    pre_t   prefix_reg, prefix_next;
    idx_t   left_reg, right_reg, scan_row_reg;
    logic   v1_reg, v2_reg, v3_reg;
    logic   first1_reg, first2_reg, lozero1_reg;
    strip_t strip_reg;
    sum_t   run_reg, best_reg;
    sum_t   max_sum_reg;
    logic   result_valid_reg;
    pre_t   hi_data, lo_data;
    logic   in_take, cfg_take, out_take, issue_last;
    idx_t   side_last_next;
    addr_t  wr_addr, hi_addr, lo_addr;
    sum_t   strip_ext;

    assign config_ready = (state_reg == ST_LOAD);
    assign element_stall = (state_reg != ST_LOAD);
    assign result_valid = result_valid_reg;
    assign max_sum = max_sum_reg;

    assign in_take = element_valid && !element_stall;
    assign cfg_take = config_valid && config_ready;
    assign out_take = result_valid_reg && !result_stall;

    always_comb
    begin
        if (side_length == '0)
        begin
            side_last_next = '0;
        end
        else if (int'(side_length) > MAX_SIDE)
        begin
            side_last_next = LAST_MAX;
        end
        else
        begin
            side_last_next = IDX_W'(side_length - SIDE_W'(1));
        end
    end

    always_comb
    begin
        if (ld_col_reg == '0)
        begin
            prefix_next = PRE_W'(element);
        end
        else
        begin
            prefix_next = prefix_reg + PRE_W'(element);
        end
    end

    assign wr_addr = {ld_row_reg, ld_col_reg};
    assign hi_addr = {scan_row_reg, right_reg};
    assign lo_addr = {scan_row_reg, left_reg - IDX_W'(1)};

    msr_ram #(.WIDTH(PRE_W), .DEPTH(DEPTH)) u_ram_hi (
        .clk     (clk),
        .wr_en   (in_take),
        .wr_addr (wr_addr),
        .wr_data (prefix_next),
        .rd_addr (hi_addr),
        .rd_data (hi_data)
    );

    msr_ram #(.WIDTH(PRE_W), .DEPTH(DEPTH)) u_ram_lo (
        .clk     (clk),
        .wr_en   (in_take),
        .wr_addr (wr_addr),
        .wr_data (prefix_next),
        .rd_addr (lo_addr),
        .rd_data (lo_data)
    );

    assign issue_last = (scan_row_reg == side_last_reg) && (right_reg == side_last_reg)
                        && (left_reg == side_last_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_take && (ld_col_reg == side_last_reg)
                    && (ld_row_reg == side_last_reg))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (issue_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!v1_reg && !v2_reg && !v3_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            side_last_reg <= LAST_MAX;
            ld_row_reg <= '0;
            ld_col_reg <= '0;
            left_reg <= '0;
            right_reg <= '0;
            scan_row_reg <= '0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_take)
            begin
                side_last_reg <= side_last_next;
                ld_row_reg <= '0;
                ld_col_reg <= '0;
            end
            else if (in_take)
            begin
                if (ld_col_reg == side_last_reg)
                begin
                    ld_col_reg <= '0;
                    if (ld_row_reg == side_last_reg)
                    begin
                        ld_row_reg <= '0;
                    end
                    else
                    begin
                        ld_row_reg <= ld_row_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    ld_col_reg <= ld_col_reg + IDX_W'(1);
                end
            end

            if (state_reg == ST_SCAN)
            begin
                if (scan_row_reg == side_last_reg)
                begin
                    scan_row_reg <= '0;
                    if (right_reg == side_last_reg)
                    begin
                        left_reg <= left_reg + IDX_W'(1);
                        right_reg <= left_reg + IDX_W'(1);
                    end
                    else
                    begin
                        right_reg <= right_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    scan_row_reg <= scan_row_reg + IDX_W'(1);
                end
            end
            else
            begin
                left_reg <= '0;
                right_reg <= '0;
                scan_row_reg <= '0;
            end

            v1_reg <= (state_reg == ST_SCAN);
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;

            if ((state_reg == ST_DONE) && (!result_valid_reg || !result_stall))
            begin
                result_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    assign strip_ext = SUM_W'(strip_reg);

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            prefix_reg <= prefix_next;
        end
        first1_reg <= (scan_row_reg == '0);
        lozero1_reg <= (left_reg == '0);
        first2_reg <= first1_reg;
        if (lozero1_reg)
        begin
            strip_reg <= STRIP_W'(hi_data);
        end
        else
        begin
            strip_reg <= STRIP_W'(hi_data) - STRIP_W'(lo_data);
        end
        if (v2_reg)
        begin
            if (first2_reg || run_reg[SUM_W-1])
            begin
                run_reg <= strip_ext;
            end
            else
            begin
                run_reg <= run_reg + strip_ext;
            end
        end
        if (state_reg == ST_LOAD)
        begin
            best_reg <= SUM_MOST_NEG;
        end
        else if (v3_reg && (run_reg > best_reg))
        begin
            best_reg <= run_reg;
        end
        if ((state_reg == ST_DONE) && (!result_valid_reg || !result_stall))
        begin
            max_sum_reg <= best_reg;
        end
    end

    a_load_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |-> (!v2_reg && !v3_reg))
        else $error("scan pipeline busy while loading");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (left_reg <= right_reg && right_reg <= side_last_reg))
        else $error("column pair out of order");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (scan_row_reg <= side_last_reg))
        else $error("scan row beyond side");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside completion");

endmodule

`default_nettype wire

>>> dv/max_sum_rectangle_test.sv
module max_sum_rectangle_test;
    timeunit 1ns;
    timeprecision 1ps;

    import msr_pkg::*;

    localparam int DRAIN_CYCLES = 16;
    localparam int RANDOM_ELEMENTS = 900;
    localparam elem_t ELEM_MAX = 16'sh7FFF;
    localparam elem_t ELEM_MIN = 16'sh8000;

    typedef enum int {
        FILL_FULL,
        FILL_SMALL,
        FILL_NEGATIVE,
        FILL_EXTREME,
        FILL_SPARSE
    } fill_t;

    typedef enum int {
        STALL_NONE,
        STALL_COIN,
        STALL_PERIODIC,
        STALL_HEAVY
    } stall_style_t;

    logic  clk;
    logic  rst_n;
    logic  config_valid;
    logic  config_ready;
    side_t side_length;
    logic  element_valid;
    logic  element_stall;
    elem_t element;
    logic  result_valid;
    logic  result_stall;
    sum_t  max_sum;

    pre_t        prefix_rows [MAX_SIDE][MAX_SIDE];
    side_t       side_setting = side_t'(MAX_SIDE);
    int unsigned loaded_count = 0;
    sum_t        pending_sums [$];
    int          error_count = 0;
    int          burst_left = 0;
    int          hold_off_cycles = 0;

    max_sum_rectangle dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .config_valid  (config_valid),
        .config_ready  (config_ready),
        .side_length   (side_length),
        .element_valid (element_valid),
        .element_stall (element_stall),
        .element       (element),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .max_sum       (max_sum)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic int unsigned active_side();
        int unsigned n;
        n = 32'(side_setting);
        if (n == 0)
            n = 1;
        if (n > MAX_SIDE)
            n = MAX_SIDE;
        return n;
    endfunction

    function automatic sum_t best_rectangle(int unsigned n);
        sum_t   best;
        sum_t   pair_best;
        sum_t   running;
        strip_t hi;
        strip_t lo;
        strip_t strip;
        best = SUM_MOST_NEG;
        for (int unsigned lo_col = 0; lo_col < n; lo_col++)
        begin
            for (int unsigned hi_col = lo_col; hi_col < n; hi_col++)
            begin
                pair_best = SUM_MOST_NEG;
                running = SUM_MOST_NEG;
                for (int unsigned row = 0; row < n; row++)
                begin
                    hi = strip_t'(prefix_rows[row][hi_col]);
                    if (lo_col > 0)
                        lo = strip_t'(prefix_rows[row][lo_col - 1]);
                    else
                        lo = '0;
                    strip = hi - lo;
                    if (running < 0)
                        running = sum_t'(strip);
                    else
                        running = running + sum_t'(strip);
                    if (running >= pair_best)
                        pair_best = running;
                end
                if (pair_best > best)
                    best = pair_best;
            end
        end
        return best;
    endfunction

    function automatic void load_element(elem_t value);
        int unsigned n;
        int unsigned total;
        int unsigned row;
        int unsigned col;
        n = active_side();
        total = n * n;
        if (loaded_count >= total)
            loaded_count = 0;
        row = loaded_count / n;
        col = loaded_count % n;
        if (col == 0)
            prefix_rows[row][col] = pre_t'(value);
        else
            prefix_rows[row][col] = prefix_rows[row][col - 1] + pre_t'(value);
        loaded_count++;
        if (loaded_count == total)
        begin
            pending_sums.push_back(best_rectangle(n));
            loaded_count = 0;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (config_valid && config_ready)
            begin
                side_setting = side_length;
                loaded_count = 0;
            end
            if (element_valid && !element_stall)
                load_element(element);
        end
    end

    always @(posedge clk)
    begin : check_result
        sum_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_sums.size() == 0)
            begin
                $display("%0t: max_sum expected none, actual %0d", $time, max_sum);
                error_count++;
            end
            else
            begin
                want = pending_sums.pop_front();
                if (max_sum !== want)
                begin
                    $display("%0t: max_sum expected %0d, actual %0d", $time, want, max_sum);
                    error_count++;
                end
            end
        end
    end

    // The receiver normally stalls in changing styles; a hold-off request from a test
    // keeps it stalled for the requested number of cycles.
    initial
    begin : receiver
        stall_style_t style;
        int           style_left;
        int unsigned  tick;
        result_stall = 1'b0;
        style = STALL_NONE;
        style_left = 0;
        tick = 0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (hold_off_cycles > 0)
            begin
                result_stall <= 1'b1;
                hold_off_cycles--;
            end
            else
            begin
                if (style_left == 0)
                begin
                    style = stall_style_t'($urandom_range(STALL_NONE, STALL_HEAVY));
                    style_left = $urandom_range(20, 200);
                end
                style_left--;
                case (style)
                    STALL_NONE:     result_stall <= 1'b0;
                    STALL_COIN:     result_stall <= 1'($urandom_range(0, 1));
                    STALL_PERIODIC: result_stall <= (tick % 5) < 2;
                    default:        result_stall <= $urandom_range(0, 7) != 0;
                endcase
            end
        end
    end

    task automatic send_element(elem_t value);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                element_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        element_valid <= 1'b1;
        element <= value;
        @(posedge clk);
        while (element_stall)
            @(posedge clk);
    endtask

    task automatic stop_sending();
        element_valid <= 1'b0;
        burst_left = 0;
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (pending_sums.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_side(side_t value);
        stop_sending();
        wait_drained();
        config_valid <= 1'b1;
        side_length <= value;
        @(posedge clk);
        while (!config_ready)
            @(posedge clk);
        config_valid <= 1'b0;
    endtask

    function automatic elem_t pick_element(fill_t fill);
        case (fill)
            FILL_FULL:
                return elem_t'($urandom);
            FILL_SMALL:
                return elem_t'(int'($urandom_range(0, 16)) - 8);
            FILL_NEGATIVE:
                if ($urandom_range(0, 7) == 0)
                    return elem_t'($urandom_range(0, 32767));
                else
                    return elem_t'(-int'($urandom_range(1, 32768)));
            FILL_EXTREME:
                case ($urandom_range(0, 3))
                    0:       return ELEM_MAX;
                    1:       return ELEM_MIN;
                    2:       return elem_t'(-1);
                    default: return elem_t'(0);
                endcase
            default:
                return ($urandom_range(0, 5) == 0) ? elem_t'($urandom) : elem_t'(0);
        endcase
    endfunction

    task automatic send_matrix(fill_t fill, int unsigned count);
        for (int unsigned i = 0; i < count; i++)
            send_element(pick_element(fill));
    endtask

    task automatic test_full_reset_side();
        repeat (MAX_SIDE * MAX_SIDE) send_element(ELEM_MAX);
    endtask

    task automatic test_degenerate_sides();
        write_side(side_t'(0));
        send_element(ELEM_MIN);
        send_element(ELEM_MAX);
        send_element(elem_t'(0));
        write_side(side_t'(1));
        send_element(elem_t'(-1));
        send_element(elem_t'(1));
    endtask

    task automatic test_small_matrices();
        write_side(side_t'(2));
        send_element(elem_t'(-5));
        send_element(elem_t'(-3));
        send_element(elem_t'(-7));
        send_element(ELEM_MIN);
        write_side(side_t'(3));
        send_element(elem_t'(2));
        send_element(elem_t'(-8));
        send_element(elem_t'(3));
        send_element(elem_t'(-1));
        send_element(elem_t'(4));
        send_element(elem_t'(-6));
        send_element(elem_t'(7));
        send_element(ELEM_MIN);
        send_element(elem_t'(5));
    endtask

    task automatic test_discard_partial();
        write_side(side_t'(MAX_SIDE));
        send_element(ELEM_MAX);
        send_element(ELEM_MAX);
        send_element(ELEM_MAX);
        write_side(side_t'(3));
        send_element(ELEM_MAX);
        send_element(elem_t'(100));
        write_side(side_t'(2));
        send_element(elem_t'(-2));
        send_element(elem_t'(9));
        send_element(elem_t'(4));
        send_element(elem_t'(-11));
    endtask

    task automatic test_oversized_side();
        write_side(side_t'(127));
        send_matrix(FILL_FULL, MAX_SIDE * MAX_SIDE);
    endtask

    // The output register fills while the receiver holds off, so the block has to
    // refuse further element requests until results can leave again.
    task automatic test_backpressure();
        write_side(side_t'(2));
        hold_off_cycles = 400;
        repeat (6) send_matrix(FILL_FULL, 4);
    endtask

    task automatic test_random_matrices();
        int unsigned sent;
        int unsigned n;
        int unsigned reps;
        int unsigned count;
        bit          broken;
        side_t       side;
        fill_t       fill;
        sent = 0;
        while (sent < RANDOM_ELEMENTS)
        begin
            case ($urandom_range(0, 9))
                0:       side = side_t'(0);
                1:       side = side_t'($urandom_range(9, 12));
                default: side = side_t'($urandom_range(1, 7));
            endcase
            write_side(side);
            n = (side == 0) ? 1 : 32'(side);
            reps = $urandom_range(1, 4);
            broken = 1'b0;
            for (int unsigned m = 0; m < reps && !broken; m++)
            begin
                fill = fill_t'($urandom_range(FILL_FULL, FILL_SPARSE));
                count = n * n;
                if ($urandom_range(0, 9) == 0)
                begin
                    count = $urandom_range(0, n * n - 1);
                    broken = 1'b1;
                end
                send_matrix(fill, count);
                sent += count;
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        config_valid = 1'b0;
        side_length = '0;
        element_valid = 1'b0;
        element = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_full_reset_side();
        test_degenerate_sides();
        test_small_matrices();
        test_discard_partial();
        test_oversized_side();
        test_backpressure();
        test_random_matrices();
        stop_sending();
        wait_drained();
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
